// ===== design/vqnce_pkg.sv =====
// ----------------------------------------------------------------------------
// vqnce_pkg
// Shared widths, codes, reset values and handshake structs of the encoder.
// ----------------------------------------------------------------------------
package vqnce_pkg;

  // Default sizing of the block.
  localparam int MAX_CODE_BITS_DEF = 8;
  localparam int MAX_DIM_DEF       = 16;
  localparam int SAMPLE_BITS_DEF   = 16;

  // Fixed field widths.
  localparam int OP_W        = 2;
  localparam int CW_W        = 8;
  localparam int CI_W        = 4;
  localparam int STATUS_W    = 2;
  localparam int DIST_W      = 40;
  localparam int CODE_BITS_W = 4;
  localparam int DIM_CFG_W   = 5;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_QUANT   = 2'd1;
  localparam logic [OP_W-1:0] OP_DEQUANT = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

  // Register indexes, taken from the word address.
  localparam logic REG_CODE_BITS = 1'b0;
  localparam logic REG_DIM       = 1'b1;

  // Register reset values.
  localparam logic [CODE_BITS_W-1:0] CODE_BITS_RST = 4'd4;
  localparam logic [DIM_CFG_W-1:0]   DIM_RST       = 5'd8;

  typedef struct packed {
    logic [CODE_BITS_W-1:0] code_bits;
    logic [DIM_CFG_W-1:0]   dim_in_use;
  } cfg_t;

  typedef struct packed {
    logic issue;  // read one accumulator and start its update
    logic zero;   // entry counts as cleared for this vector
  } dist_ctrl_t;

  typedef struct packed {
    logic busy;   // updates still in the accumulator pipeline
  } dist_sts_t;

endpackage

// ===== design/vqnce_cfg.sv =====
// ----------------------------------------------------------------------------
// vqnce_cfg
// APB-style register file holding code_bits and dim_in_use.
// ----------------------------------------------------------------------------
module vqnce_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vqnce_pkg::APB_AW-1:0]  paddr,
  input  logic [vqnce_pkg::APB_DW-1:0]  pwdata,
  output logic [vqnce_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  output vqnce_pkg::cfg_t               cfg
);
  import vqnce_pkg::*;

  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_AW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_bits  <= CODE_BITS_RST;
      cfg.dim_in_use <= DIM_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_CODE_BITS: cfg.code_bits  <= pwdata[CODE_BITS_W-1:0];
        REG_DIM:       cfg.dim_in_use <= pwdata[DIM_CFG_W-1:0];
        default:       cfg.code_bits  <= cfg.code_bits;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CODE_BITS: prdata = APB_DW'(cfg.code_bits);
      REG_DIM:       prdata = APB_DW'(cfg.dim_in_use);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== design/vqnce_book.sv =====
// ----------------------------------------------------------------------------
// vqnce_book
// Codebook store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vqnce_book #(
  parameter int ADDR_W      = 12,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ADDR_W-1:0]             waddr,
  input  logic signed [SAMPLE_BITS-1:0] wdata,
  input  logic                          re,
  input  logic [ADDR_W-1:0]             raddr,
  output logic signed [SAMPLE_BITS-1:0] rdata
);

  logic signed [SAMPLE_BITS-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/vqnce_dist.sv =====
// ----------------------------------------------------------------------------
// vqnce_dist
// Distance accumulator memory with a four-stage read-modify-write pipeline
// and a running minimum over the entries updated in a pass.
// ----------------------------------------------------------------------------
module vqnce_dist #(
  parameter int MAX_CODE_BITS = 8,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  vqnce_pkg::dist_ctrl_t         ctrl,
  input  logic [MAX_CODE_BITS-1:0]      idx,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [SAMPLE_BITS-1:0] cb_rdata,
  output vqnce_pkg::dist_sts_t          sts,
  output logic [MAX_CODE_BITS-1:0]      near_idx,
  output logic [vqnce_pkg::DIST_W-1:0]  near_sum
);
  import vqnce_pkg::*;

  localparam int MAG_W = SAMPLE_BITS + 1;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int EXT_W = (SQ_W > DIST_W) ? SQ_W : DIST_W;

  logic [DIST_W-1:0] acc_mem [2**MAX_CODE_BITS];

  logic                     v1, v2, v3, v4;
  logic                     zero1;
  logic [MAX_CODE_BITS-1:0] idx1, idx2, idx3, idx4;
  logic [DIST_W-1:0]        acc_rd, acc2, acc3, new4;
  logic [MAG_W-1:0]         mag2;
  logic [SQ_W-1:0]          sq3;

  logic signed [MAG_W-1:0]  diff;
  logic [MAG_W-1:0]         mag;
  logic [EXT_W-1:0]         sq_ext;
  logic [DIST_W-1:0]        sq_sat;
  logic [DIST_W:0]          sum;
  logic [DIST_W-1:0]        sum_sat;

  // Stage 1: difference and magnitude.
  assign diff = {x[SAMPLE_BITS-1], x} - {cb_rdata[SAMPLE_BITS-1], cb_rdata};
  assign mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

  // Stage 3: saturating accumulate.
  assign sq_ext  = EXT_W'(sq3);
  assign sq_sat  = (sq_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : sq_ext[DIST_W-1:0];
  assign sum     = {1'b0, acc3} + {1'b0, sq_sat};
  assign sum_sat = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

  assign sts.busy = v1 | v2 | v3 | v4;

  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      acc_rd <= acc_mem[idx];
    end
    if (v3) begin
      acc_mem[idx3] <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= ctrl.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    idx1  <= idx;
    zero1 <= ctrl.zero;
    idx2  <= idx1;
    mag2  <= mag;
    acc2  <= zero1 ? '0 : acc_rd;
    idx3  <= idx2;
    sq3   <= mag2 * mag2;
    acc3  <= acc2;
    idx4  <= idx3;
    new4  <= sum_sat;
    // The first entry of a pass seeds the minimum; only a strictly smaller
    // distance replaces it, so ties keep the lower index.
    if (v4 && ((idx4 == '0) || (new4 < near_sum))) begin
      near_idx <= idx4;
      near_sum <= new4;
    end
  end

endmodule

// ===== design/vq_nearest_codeword_encoder.sv =====
// ----------------------------------------------------------------------------
// vq_nearest_codeword_encoder
// A quantize component runs one accumulator read-modify-write per active
// codeword through the single read port of each memory; the result of a
// vector follows once the last update of its final component has drained.
// A dequantize request gives its components one at a time, each by a codebook
// read, then an output load that can stall; no new input is taken meanwhile.
// Reset clears control state only; the codebook is undefined until written.
// ----------------------------------------------------------------------------
module vq_nearest_codeword_encoder #(
  parameter int MAX_CODE_BITS = vqnce_pkg::MAX_CODE_BITS_DEF,
  parameter int MAX_DIM       = vqnce_pkg::MAX_DIM_DEF,
  parameter int SAMPLE_BITS   = vqnce_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vqnce_pkg::APB_AW-1:0]    paddr,
  input  logic [vqnce_pkg::APB_DW-1:0]    pwdata,
  output logic [vqnce_pkg::APB_DW-1:0]    prdata,
  output logic                            pready,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [vqnce_pkg::OP_W-1:0]      op,
  input  logic [vqnce_pkg::CW_W-1:0]      codeword_index,
  input  logic [vqnce_pkg::CI_W-1:0]      component_index,
  input  logic signed [SAMPLE_BITS-1:0]   value,
  input  logic                            last,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [vqnce_pkg::STATUS_W-1:0]  status,
  output logic [vqnce_pkg::CW_W-1:0]      code_index,
  output logic [vqnce_pkg::DIST_W-1:0]    distance,
  output logic signed [SAMPLE_BITS-1:0]   component,
  output logic                            last_out
);
  import vqnce_pkg::*;

  // The codebook stores codeword c, component k at {c, k}, so each codeword
  // occupies a power-of-two block of the store.
  localparam int DIM_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DCNT_W     = $clog2(MAX_DIM + 1);
  localparam int WCNT_W     = MAX_CODE_BITS + 1;
  localparam int ADDR_W     = MAX_CODE_BITS + DIM_W;
  localparam int BOOK_WORDS = 1 << MAX_CODE_BITS;

  // Sequencer states.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_QPASS   = 3'd1;
  localparam logic [2:0] S_QDRAIN  = 3'd2;
  localparam logic [2:0] S_RES     = 3'd3;
  localparam logic [2:0] S_DQ_RD   = 3'd4;
  localparam logic [2:0] S_DQ_WAIT = 3'd5;

  logic [2:0] state, state_next;

  cfg_t       cfg;
  dist_ctrl_t dctrl;
  dist_sts_t  dsts;

  // Effective configuration after saturation into the legal ranges.
  logic [CODE_BITS_W-1:0] bits_act;
  logic [WCNT_W-1:0]      words;
  logic [DCNT_W-1:0]      dim_act;

  // Vector tracking. vec_hi counts the accumulator entries touched since the
  // vector began; the touched entries always form a prefix, so every entry at
  // or above it is treated as cleared and read as zero, whatever it holds.
  logic [DIM_W-1:0]  comp_cnt;
  logic [WCNT_W-1:0] vec_hi;
  logic [WCNT_W-1:0] zhi, zhi_r;
  logic [DCNT_W-1:0] pos_inc;
  logic              q_end;
  logic              book_ready;

  // Item registers.
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic [DIM_W-1:0]              pos_r;
  logic                          q_final;
  logic [CW_W-1:0]               cw_r;
  logic [WCNT_W-1:0]             iss;
  logic [DIM_W-1:0]              k;
  logic                          k_last;

  // Pending single-beat result.
  logic [STATUS_W-1:0] res_status;
  logic [CW_W-1:0]     res_idx;
  logic [DIST_W-1:0]   res_dist;

  // Codebook ports.
  logic                          cb_we, cb_re;
  logic [ADDR_W-1:0]             cb_waddr, cb_raddr;
  logic signed [SAMPLE_BITS-1:0] cb_rdata;

  logic [MAX_CODE_BITS-1:0] near_idx;
  logic [DIST_W-1:0]        near_sum;

  logic in_acc, out_free, out_load;
  logic cw_ok, ci_ok;

  vqnce_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vqnce_book #(
    .ADDR_W      (ADDR_W),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_book (
    .clk   (clk),
    .we    (cb_we),
    .waddr (cb_waddr),
    .wdata (value),
    .re    (cb_re),
    .raddr (cb_raddr),
    .rdata (cb_rdata)
  );

  vqnce_dist #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (dctrl),
    .idx       (iss[MAX_CODE_BITS-1:0]),
    .x         (x_r),
    .cb_rdata  (cb_rdata),
    .sts       (dsts),
    .near_idx  (near_idx),
    .near_sum  (near_sum)
  );

  // Saturate the registers: code_bits into 1..MAX_CODE_BITS, dim_in_use
  // into 1..MAX_DIM.
  always_comb begin
    if (cfg.code_bits == '0) begin
      bits_act = CODE_BITS_W'(1);
    end else if (int'(cfg.code_bits) > MAX_CODE_BITS) begin
      bits_act = CODE_BITS_W'(MAX_CODE_BITS);
    end else begin
      bits_act = cfg.code_bits;
    end
    if (cfg.dim_in_use == '0) begin
      dim_act = DCNT_W'(1);
    end else if (int'(cfg.dim_in_use) > MAX_DIM) begin
      dim_act = DCNT_W'(MAX_DIM);
    end else begin
      dim_act = DCNT_W'(cfg.dim_in_use);
    end
  end

  assign words = WCNT_W'(1) << bits_act;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // A quantize component ends its vector when flagged last or when it is
  // component number dim_in_use after saturation.
  assign pos_inc = DCNT_W'(comp_cnt) + DCNT_W'(1);
  assign q_end   = last || !(pos_inc < dim_act);
  assign zhi     = (comp_cnt == '0) ? '0 : vec_hi;

  // A write outside the store changes nothing but may still mark the book.
  assign cw_ok    = int'(codeword_index) < BOOK_WORDS;
  assign ci_ok    = int'(component_index) < MAX_DIM;
  assign cb_we    = in_acc && (op == OP_WRITE) && cw_ok && ci_ok;
  assign cb_waddr = {MAX_CODE_BITS'(codeword_index), DIM_W'(component_index)};

  // The codebook read port serves the quantize pass and dequantize reads.
  assign cb_re    = (state == S_QPASS) || (state == S_DQ_RD);
  assign cb_raddr = (state == S_QPASS) ? {iss[MAX_CODE_BITS-1:0], pos_r}
                                       : {MAX_CODE_BITS'(cw_r), k};

  assign dctrl.issue = (state == S_QPASS);
  assign dctrl.zero  = (iss >= zhi_r);

  assign k_last   = ((DCNT_W'(k) + DCNT_W'(1)) == dim_act);
  assign out_load = ((state == S_RES) || (state == S_DQ_WAIT)) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (op == OP_QUANT) begin
            state_next = S_QPASS;
          end else if (op == OP_DEQUANT) begin
            if (!book_ready || (int'(codeword_index) >= int'(words))) begin
              state_next = S_RES;
            end else begin
              state_next = S_DQ_RD;
            end
          end
        end
      end
      S_QPASS: begin
        if (iss == (words - WCNT_W'(1))) begin
          state_next = S_QDRAIN;
        end
      end
      S_QDRAIN: begin
        if (!dsts.busy) begin
          state_next = q_final ? S_RES : S_IDLE;
        end
      end
      S_RES: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_DQ_RD: begin
        state_next = S_DQ_WAIT;
      end
      S_DQ_WAIT: begin
        if (out_free) begin
          state_next = k_last ? S_IDLE : S_DQ_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      comp_cnt   <= '0;
      vec_hi     <= '0;
      book_ready <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc && (op == OP_WRITE) && last) begin
        book_ready <= 1'b1;
      end
      if (in_acc && (op == OP_QUANT)) begin
        comp_cnt <= q_end ? '0 : DIM_W'(pos_inc);
        vec_hi   <= (zhi > words) ? zhi : words;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    if (in_acc && (op == OP_QUANT)) begin
      x_r     <= value;
      pos_r   <= comp_cnt;
      zhi_r   <= zhi;
      q_final <= q_end;
      iss     <= '0;
    end else if (state == S_QPASS) begin
      iss <= iss + WCNT_W'(1);
    end

    if (in_acc && (op == OP_DEQUANT)) begin
      cw_r       <= codeword_index;
      k          <= '0;
      res_idx    <= codeword_index;
      res_dist   <= '0;
      res_status <= book_ready ? ST_RANGE : ST_NOT_READY;
    end else if ((state == S_DQ_WAIT) && out_free) begin
      k <= k + DIM_W'(1);
    end

    // The search result stands once the last update has left the pipeline.
    if ((state == S_QDRAIN) && !dsts.busy) begin
      res_status <= book_ready ? ST_OK : ST_NOT_READY;
      res_idx    <= book_ready ? CW_W'(near_idx) : '0;
      res_dist   <= book_ready ? near_sum : '0;
    end

    if (out_load) begin
      if (state == S_RES) begin
        status     <= res_status;
        code_index <= res_idx;
        distance   <= res_dist;
        component  <= '0;
        last_out   <= 1'b1;
      end else begin
        status     <= ST_OK;
        code_index <= cw_r;
        distance   <= '0;
        component  <= cb_rdata;
        last_out   <= k_last;
      end
    end
  end

`ifndef SYNTH
  // No accumulator update may still be in flight when a new item is taken.
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !dsts.busy)
    else $error("accumulator pipeline busy while idle");

  // The output register is only loaded when it is empty or being emptied.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken beat");

  // The pass never touches a codeword beyond the active size.
  a_issue_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_QPASS) |-> (iss < words))
    else $error("accumulator issue beyond active codewords");

  // A quantize component always starts a pass over the accumulators.
  a_quant_pass: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (op == OP_QUANT)) |=> (state == S_QPASS))
    else $error("quantize component did not start a pass");
`endif

endmodule

// ===== tb/vq_nearest_codeword_encoder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vq_nearest_codeword_encoder_test
// Self-checking bench for the nearest-codeword vector quantizer. A scoreboard
// keeps its own copy of the codebook, the per-codeword distance sums and the
// register file. It predicts every result beat from the accepted input beats,
// and the received beats are checked against it in order. Stimulus is a
// preload of the first sixteen codewords, a short directed part, then random
// phases over several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module vq_nearest_codeword_encoder_test;
  import vqnce_pkg::*;

  localparam int CODE_WORDS = 1 << MAX_CODE_BITS_DEF;
  localparam int DIM_SLOTS  = MAX_DIM_DEF;
  // Only this many codewords are preloaded, so every register setting used
  // below keeps the active book inside them.
  localparam int PRELOAD_WORDS = 16;
  // One quantize component at the largest book fits well inside this, so it is
  // enough quiet time for any write or open component to retire.
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT   = 1_000_000;
  // The fourth operation code has no meaning and must be ignored.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [CW_W-1:0]     code_index;
    logic [DIST_W-1:0]   distance;
    logic signed [15:0]  component;
    logic                last_out;
  } vq_result_t;

  // The scoreboard holds the mirrored state and the queue of result beats
  // that the block still owes.
  class vq_scoreboard;
    logic signed [15:0]     book [CODE_WORDS][DIM_SLOTS];
    longint unsigned        dist_acc [CODE_WORDS];
    int                     comp_pos;
    bit                     book_ready;
    logic [CODE_BITS_W-1:0] code_bits;
    logic [DIM_CFG_W-1:0]   dim_in_use;
    vq_result_t             owed_results [$];
    int                     mismatches;

    function new();
      comp_pos   = 0;
      book_ready = 0;
      code_bits  = CODE_BITS_RST;
      dim_in_use = DIM_RST;
      mismatches = 0;
      foreach (book[i, j]) book[i][j] = '0;
      foreach (dist_acc[i]) dist_acc[i] = 0;
    endfunction

    // Out-of-range register values saturate into the legal range.
    function int active_words();
      int b;
      b = code_bits;
      if (b < 1) b = 1;
      if (b > MAX_CODE_BITS_DEF) b = MAX_CODE_BITS_DEF;
      return 1 << b;
    endfunction

    function int active_dim();
      int d;
      d = dim_in_use;
      if (d < 1) d = 1;
      if (d > MAX_DIM_DEF) d = MAX_DIM_DEF;
      return d;
    endfunction

    function void set_reg(logic reg_idx, logic [APB_DW-1:0] data);
      if (reg_idx == REG_CODE_BITS) code_bits = data[CODE_BITS_W-1:0];
      else dim_in_use = data[DIM_CFG_W-1:0];
    endfunction

    function void owe(logic [STATUS_W-1:0] st, logic [CW_W-1:0] idx,
                      logic [DIST_W-1:0] dist_val, logic signed [15:0] comp,
                      logic lst);
      vq_result_t r;
      r.status     = st;
      r.code_index = idx;
      r.distance   = dist_val;
      r.component  = comp;
      r.last_out   = lst;
      owed_results.push_back(r);
    endfunction

    // Updates the mirrored state for one accepted input beat and queues the
    // result beats that it causes.
    function void absorb_item(logic [OP_W-1:0] kind, logic [CW_W-1:0] cw,
                              logic [CI_W-1:0] ci, logic signed [15:0] x,
                              logic lst);
      int              words;
      int              dim;
      int              best;
      longint          diff;
      longint unsigned sq;
      longint unsigned best_d;
      longint unsigned dmax;
      words = active_words();
      dim   = active_dim();
      dmax  = longint'(DIST_MAX);
      case (kind)
        OP_WRITE: begin
          book[cw][ci] = x;
          if (lst) book_ready = 1;
        end
        OP_QUANT: begin
          if (comp_pos == 0) foreach (dist_acc[i]) dist_acc[i] = 0;
          for (int i = 0; i < words; i++) begin
            diff = longint'(x) - longint'(book[i][comp_pos]);
            sq   = diff * diff;
            if (sq > dmax) sq = dmax;
            dist_acc[i] = (dist_acc[i] > dmax - sq) ? dmax : dist_acc[i] + sq;
          end
          if (!lst && comp_pos + 1 < dim) begin
            comp_pos++;
          end else begin
            comp_pos = 0;
            if (!book_ready) begin
              owe(ST_NOT_READY, '0, '0, '0, 1'b1);
            end else begin
              best   = 0;
              best_d = dist_acc[0];
              // A strict compare keeps the lower index on a tie.
              for (int i = 1; i < words; i++) begin
                if (dist_acc[i] < best_d) begin
                  best_d = dist_acc[i];
                  best   = i;
                end
              end
              owe(ST_OK, best[CW_W-1:0], best_d[DIST_W-1:0], '0, 1'b1);
            end
          end
        end
        OP_DEQUANT: begin
          if (!book_ready) begin
            owe(ST_NOT_READY, cw, '0, '0, 1'b1);
          end else if (cw >= words) begin
            owe(ST_RANGE, cw, '0, '0, 1'b1);
          end else begin
            for (int k = 0; k < dim; k++) owe(ST_OK, cw, '0, book[cw][k], k + 1 == dim);
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task match_result(vq_result_t got);
      vq_result_t want;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat, status %0d index %0d",
                                  got.status, got.code_index));
      end else begin
        want = owed_results.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.code_index !== want.code_index)
          report_mismatch($sformatf("code_index %0d, want %0d",
                                    got.code_index, want.code_index));
        if (got.distance !== want.distance)
          report_mismatch($sformatf("distance %0d, want %0d", got.distance, want.distance));
        if (got.component !== want.component)
          report_mismatch($sformatf("component %0d, want %0d",
                                    got.component, want.component));
        if (got.last_out !== want.last_out)
          report_mismatch($sformatf("last_out %0b, want %0b", got.last_out, want.last_out));
      end
    endtask

    task check_leftover();
      while (owed_results.size() != 0) begin
        void'(owed_results.pop_front());
        report_mismatch("expected result beat never arrived");
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_ready;
  logic [OP_W-1:0]       op;
  logic [CW_W-1:0]       codeword_index;
  logic [CI_W-1:0]       component_index;
  logic signed [15:0]    value;
  logic                  last;
  logic                  out_valid;
  logic                  out_ready;
  logic [STATUS_W-1:0]   status;
  logic [CW_W-1:0]       code_index;
  logic [DIST_W-1:0]     distance;
  logic signed [15:0]    component;
  logic                  last_out;

  vq_scoreboard sb;
  // While steady is set, neither channel idles, which gives long stretches
  // of back-to-back beats.
  bit           steady;
  int unsigned  cycle_count;

  vq_nearest_codeword_encoder i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** vq_nearest_codeword_encoder: FAILED **");
      $finish;
    end
  end

  function automatic int draw_idle();
    if (steady) return 0;
    return $urandom_range(0, 8);
  endfunction

  // Mostly full-range random samples, with the extremes and the values
  // around zero mixed in often.
  function automatic logic signed [15:0] draw_sample();
    case ($urandom_range(0, 11))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Drives one input beat. Inputs change only at the falling edge; the
  // beat counts at the first rising edge that sees in_ready high. With no
  // idle cycle drawn, in_valid simply stays high into the next beat.
  task automatic send_item(logic [OP_W-1:0] kind, logic [CW_W-1:0] cw,
                           logic [CI_W-1:0] ci, logic signed [15:0] x, logic lst);
    int gap;
    gap = draw_idle();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    op              = kind;
    codeword_index  = cw;
    component_index = ci;
    value           = x;
    last            = lst;
    in_valid        = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.absorb_item(kind, cw, ci, x, lst);
  endtask

  // Register write: a setup phase, then an access phase that completes at
  // the rising edge with pready high. Only called while the block is idle.
  task automatic apb_write(logic reg_idx, logic [APB_DW-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {reg_idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(reg_idx, data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Closes any open quantize vector, stops the sender, waits for every owed
  // result beat and then lets the block go quiet. This is also where the
  // sender holds off until the result side has fully drained.
  task automatic settle_block();
    if (sb.comp_pos != 0)
      send_item(OP_QUANT, CW_W'($urandom), CI_W'($urandom), draw_sample(), 1'b1);
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random beat. Quantize components dominate and mostly form complete
  // vectors: the final component usually carries last, a few vectors end
  // early on last, and the rest end on the component count alone.
  // Returns 0 for the ignored operation so that it does not count.
  task automatic random_item(output bit counted);
    int pick;
    logic [CW_W-1:0] cw;
    logic lst;
    pick    = $urandom_range(0, 99);
    counted = 1;
    if (pick < 8) begin
      send_item(OP_WRITE, CW_W'($urandom), CI_W'($urandom), draw_sample(),
                $urandom_range(0, 3) == 0);
    end else if (pick < 18) begin
      if ($urandom_range(0, 3) == 0) cw = CW_W'($urandom);
      else cw = CW_W'($urandom_range(0, sb.active_words() - 1));
      send_item(OP_DEQUANT, cw, CI_W'($urandom), draw_sample(), 1'($urandom));
    end else if (pick < 21) begin
      send_item(OP_UNUSED, CW_W'($urandom), CI_W'($urandom), draw_sample(),
                1'($urandom));
      counted = 0;
    end else begin
      if (sb.comp_pos + 1 == sb.active_dim()) lst = $urandom_range(0, 3) != 0;
      else lst = $urandom_range(0, 11) == 0;
      send_item(OP_QUANT, CW_W'($urandom), CI_W'($urandom), draw_sample(), lst);
    end
  endtask

  // Result side: draws a stall before each beat, then holds out_ready high
  // until a beat is taken and hands it to the scoreboard.
  initial begin
    int stall;
    vq_result_t got;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = draw_idle();
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      got.status     = status;
      got.code_index = code_index;
      got.distance   = distance;
      got.component  = component;
      got.last_out   = last_out;
      sb.match_result(got);
    end
  end

  initial begin
    int cb_list [8];
    int dim_list [8];
    int len_list [8];
    int n;
    bit counted;
    cb_list  = '{1, 4, 0, 3, 2, 4, 1, 4};
    dim_list = '{16, 2, 31, 5, 17, 1, 3, 8};
    len_list = '{20, 20, 15, 25, 25, 20, 20, 25};
    sb = new();
    steady          = 1'b0;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid        = 1'b0;
    op              = OP_WRITE;
    codeword_index  = '0;
    component_index = '0;
    value           = '0;
    last            = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill every component of the codewords that any setting below can
    // reach before anything reads them. No write carries last, so the book
    // stays not ready for the first directed checks.
    steady = 1'b1;
    for (int w = 0; w < PRELOAD_WORDS; w++) begin
      for (int c = 0; c < DIM_SLOTS; c++)
        send_item(OP_WRITE, CW_W'(w), CI_W'(c), draw_sample(), 1'b0);
    end
    steady = 1'b0;

    // Not ready: a quantize vector ended early by last, and dequantize
    // requests at both ends of the index range.
    send_item(OP_QUANT, 8'd0, 4'd0, 16'sh7FFF, 1'b0);
    send_item(OP_QUANT, 8'd0, 4'd0, 16'sh8000, 1'b1);
    send_item(OP_DEQUANT, 8'd0, 4'd0, 16'sh0000, 1'b0);
    send_item(OP_DEQUANT, 8'd255, 4'd15, 16'sh0000, 1'b0);
    // A write flagged last marks the book ready; then the extreme entries.
    send_item(OP_WRITE, 8'd0, 4'd0, 16'sh8000, 1'b1);
    send_item(OP_WRITE, 8'd255, 4'd15, 16'sh7FFF, 1'b0);
    // Dequantize of the top active codeword, then indices out of range.
    send_item(OP_DEQUANT, 8'd15, 4'd0, 16'sh0000, 1'b0);
    send_item(OP_DEQUANT, 8'd16, 4'd0, 16'sh0000, 1'b0);
    send_item(OP_DEQUANT, 8'd255, 4'd0, 16'sh0000, 1'b1);
    // The unused operation must leave no trace.
    send_item(OP_UNUSED, 8'd255, 4'd15, 16'shFFFF, 1'b1);
    // A full vector of extreme samples that ends on the component count.
    for (int c = 0; c < 8; c++)
      send_item(OP_QUANT, 8'd0, 4'd0, (c % 2) ? 16'sh8000 : 16'sh7FFF, 1'b0);
    settle_block();

    // Zero in both registers saturates to two codewords of one component.
    // Codewords at 100 and 300 are equally far from 200: the lower wins.
    apb_write(REG_CODE_BITS, 32'd0);
    apb_write(REG_DIM, 32'd0);
    send_item(OP_WRITE, 8'd0, 4'd0, 16'sd100, 1'b0);
    send_item(OP_WRITE, 8'd1, 4'd0, 16'sd300, 1'b0);
    send_item(OP_QUANT, 8'd0, 4'd0, 16'sd200, 1'b0);
    settle_block();

    // Random phases, each under its own register setting. Settings include
    // the largest preloaded book, the longest vector and values that
    // saturate.
    for (int p = 0; p < 8; p++) begin
      apb_write(REG_CODE_BITS, cb_list[p]);
      apb_write(REG_DIM, dim_list[p]);
      n = 0;
      while (n < len_list[p]) begin
        if (n % 32 == 0) steady = $urandom_range(0, 3) == 0;
        random_item(counted);
        if (counted) n++;
      end
      steady = 1'b0;
      settle_block();
    end

    sb.check_leftover();
    if (sb.mismatches == 0) begin
      $display("** vq_nearest_codeword_encoder: PASSED **");
    end else begin
      $display("** vq_nearest_codeword_encoder: FAILED **");
    end
    $finish;
  end

endmodule
